FILE: src/cel_packed_row_pixel_decoder_top_defines.svh
// Assertion macros for the packed row pixel decoder.
`ifndef CEL_PACKED_ROW_PIXEL_DECODER_TOP_DEFINES_SVH
`define CEL_PACKED_ROW_PIXEL_DECODER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define CPRD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CPRD_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPRD_ASSERT_RST(lbl, prop, msg)
`define CPRD_ASSERT_CLK(lbl, prop, msg)
`endif
`endif

FILE: src/cprd_pkg.sv
`default_nettype none
package cprd_pkg;

  localparam int PALETTE_DEPTH_DEF = 32;
  localparam int MAX_WIDTH_DEF     = 2047;
  localparam int MAX_RESULTS       = 64;

  localparam logic [2:0] REG_DEPTH_CODE     = 3'd0;
  localparam logic [2:0] REG_UNCODED_MODE   = 3'd1;
  localparam logic [2:0] REG_PACKED_MODE    = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd3;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_PALETTE_COUNT  = 3'd5;
  localparam logic [2:0] REG_PREAMBLE_BYTES = 3'd6;

  localparam logic KIND_PALETTE = 1'b0;

  typedef struct packed {
    logic        kind;
    logic [15:0] data_word;
    logic [4:0]  palette_slot;
    logic        frame_start;
  } item_t;

  typedef struct packed {
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        run_last;
  } pixel_t;

  typedef struct packed {
    logic [2:0]  depth_code;
    logic        uncoded_mode;
    logic        packed_mode;
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [5:0]  palette_count;
    logic [2:0]  preamble_bytes;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [15:0] raw;
    logic        is16;
  } colour_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } colour_rsp_t;

  typedef struct packed {
    logic        we;
    logic [4:0]  slot;
    logic [14:0] word;
  } pal_wr_t;

  typedef struct packed {
    logic        push;
    logic        flush;
    logic [10:0] x;
    logic [10:0] y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } emit_t;

  typedef struct packed {
    logic push_ready;
    logic flush_ready;
  } out_status_t;

  function automatic logic [4:0] depth_bits(input logic [2:0] code);
    logic [4:0] b;
    unique case (code)
      3'd1: b = 5'd1;
      3'd2: b = 5'd2;
      3'd3: b = 5'd4;
      3'd4: b = 5'd6;
      3'd5: b = 5'd8;
      3'd6: b = 5'd16;
      default: b = 5'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] expand5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

endpackage
`default_nettype wire

FILE: src/cel_packed_row_pixel_decoder_top.sv
`default_nettype none
// Palettized run-length sprite pixel decoder. Palette loads and data bytes enter on the
// item channel; each drawn pixel leaves on the pixel channel with its column, row and
// 8-bit RGB, and run_last marks the final pixel caused by a byte. One item is decoded at
// a time; a palette load is written when it is accepted. A data byte passes through
// bookkeeping (accept, dispatch, row-end check, output flush), the control and value
// steps, the bits shifted out of the bit buffer (8 per packet control, bpp per pixel
// value) and the colour lookup per value: direct when uncoded, else through the palette
// (start, 5-step serial modulo, RAM read, expand, handoff); then each pixel is emitted.
// The shifter takes one bit per cycle and the palette modulo is serial. An output
// register with one pending slot lets the next pixel be prepared while the last one
// waits. Configuration registers are written through cfg_we/cfg_index/cfg_data.
module cel_packed_row_pixel_decoder_top #(
  parameter int PALETTE_DEPTH = cprd_pkg::PALETTE_DEPTH_DEF,
  parameter int MAX_WIDTH     = cprd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire cprd_pkg::item_t  item,
  output logic                  pixel_valid,
  input  wire logic             pixel_stall,
  output cprd_pkg::pixel_t      pixel,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [10:0]      cfg_data
);

  cprd_pkg::cfg_t        cfg;
  cprd_pkg::pal_wr_t     pal_wr;
  cprd_pkg::colour_req_t creq;
  cprd_pkg::colour_rsp_t crsp;
  cprd_pkg::emit_t       em;
  cprd_pkg::out_status_t status;
  logic                  busy;

  assign item_stall = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.depth_code     <= 3'd5;
      cfg.uncoded_mode   <= 1'b0;
      cfg.packed_mode    <= 1'b1;
      cfg.image_width    <= 11'd320;
      cfg.image_height   <= 11'd240;
      cfg.palette_count  <= 6'd32;
      cfg.preamble_bytes <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cprd_pkg::REG_DEPTH_CODE:     cfg.depth_code     <= cfg_data[2:0];
        cprd_pkg::REG_UNCODED_MODE:   cfg.uncoded_mode   <= cfg_data[0];
        cprd_pkg::REG_PACKED_MODE:    cfg.packed_mode    <= cfg_data[0];
        cprd_pkg::REG_IMAGE_WIDTH:    cfg.image_width    <= cfg_data;
        cprd_pkg::REG_IMAGE_HEIGHT:   cfg.image_height   <= cfg_data;
        cprd_pkg::REG_PALETTE_COUNT:  cfg.palette_count  <= cfg_data[5:0];
        cprd_pkg::REG_PREAMBLE_BYTES: cfg.preamble_bytes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  cprd_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .busy       (busy),
    .pal_wr     (pal_wr),
    .creq       (creq),
    .crsp       (crsp),
    .em         (em),
    .status     (status)
  );

  cprd_colour #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_colour (
    .clk           (clk),
    .rst           (rst),
    .uncoded_mode  (cfg.uncoded_mode),
    .palette_count (cfg.palette_count),
    .pal_wr        (pal_wr),
    .req           (creq),
    .rsp           (crsp)
  );

  cprd_out u_out (
    .clk         (clk),
    .rst         (rst),
    .em          (em),
    .status      (status),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

endmodule
`default_nettype wire

FILE: src/cprd_colour.sv
`default_nettype none
module cprd_colour #(
  parameter int PALETTE_DEPTH = cprd_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  uncoded_mode,
  input  wire logic [5:0]            palette_count,
  input  wire cprd_pkg::pal_wr_t     pal_wr,
  input  wire cprd_pkg::colour_req_t req,
  output cprd_pkg::colour_rsp_t      rsp
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  typedef enum logic [1:0] {C_IDLE, C_MOD, C_READ, C_EXP} cstate_t;

  cstate_t     cst;
  logic [14:0] mem [PALETTE_DEPTH];
  logic [14:0] rd;
  logic [15:0] raw_r;
  logic [4:0]  idx;
  logic [4:0]  rem;
  logic [2:0]  step;
  logic        grey;
  logic        use_pal;
  logic [5:0]  cnt_eff;
  logic [5:0]  trial;
  logic [14:0] word;

  assign cnt_eff = (palette_count == 6'd0 || palette_count > 6'(PALETTE_DEPTH)) ?
                   6'(PALETTE_DEPTH) : palette_count;
  assign trial   = {rem, idx[4]};
  assign word    = use_pal ? rd : raw_r[14:0];

  always_ff @(posedge clk) begin
    if (pal_wr.we && {1'b0, pal_wr.slot} < 6'(PALETTE_DEPTH)) begin
      mem[pal_wr.slot[AW-1:0]] <= pal_wr.word;
    end
    if (cst == C_READ) begin
      rd <= mem[rem[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst      <= C_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (cst)
        C_IDLE: begin
          if (req.start) begin
            raw_r <= req.raw;
            if (uncoded_mode) begin
              grey    <= !req.is16;
              use_pal <= 1'b0;
              cst     <= C_EXP;
            end else begin
              grey    <= 1'b0;
              use_pal <= 1'b1;
              idx     <= req.raw[4:0];
              rem     <= 5'd0;
              step    <= 3'd0;
              cst     <= C_MOD;
            end
          end
        end
        C_MOD: begin
          rem  <= (trial >= cnt_eff) ? 5'(trial - cnt_eff) : trial[4:0];
          idx  <= {idx[3:0], 1'b0};
          step <= step + 3'd1;
          if (step == 3'd4) begin
            cst <= C_READ;
          end
        end
        C_READ: cst <= C_EXP;
        C_EXP: begin
          if (grey) begin
            rsp.red   <= raw_r[7:0];
            rsp.green <= raw_r[7:0];
            rsp.blue  <= raw_r[7:0];
          end else begin
            rsp.red   <= cprd_pkg::expand5(word[14:10]);
            rsp.green <= cprd_pkg::expand5(word[9:5]);
            rsp.blue  <= cprd_pkg::expand5(word[4:0]);
          end
          rsp.done <= 1'b1;
          cst      <= C_IDLE;
        end
        default: cst <= C_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: src/cprd_out.sv
`default_nettype none
module cprd_out (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cprd_pkg::emit_t     em,
  output cprd_pkg::out_status_t    status,
  output logic                     pixel_valid,
  input  wire logic                pixel_stall,
  output cprd_pkg::pixel_t         pixel
);

  logic            pend_valid;
  cprd_pkg::emit_t pend;
  logic            free;

  assign free               = !pixel_valid || !pixel_stall;
  assign status.push_ready  = !pend_valid || free;
  assign status.flush_ready = !pend_valid || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid  <= 1'b0;
      pixel_valid <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        pixel_valid <= 1'b0;
      end
      if (em.push) begin
        if (pend_valid) begin
          pixel_valid <= 1'b1;
          pixel       <= {pend.x, pend.y, pend.red, pend.green, pend.blue, 1'b0};
        end
        pend       <= em;
        pend_valid <= 1'b1;
      end else if (em.flush && pend_valid && free) begin
        pixel_valid <= 1'b1;
        pixel       <= {pend.x, pend.y, pend.red, pend.green, pend.blue, 1'b1};
        pend_valid  <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/cprd_core.sv
`default_nettype none
`include "cel_packed_row_pixel_decoder_top_defines.svh"
module cprd_core #(
  parameter int MAX_WIDTH = cprd_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cprd_pkg::cfg_t        cfg,
  input  wire logic                  item_valid,
  input  wire cprd_pkg::item_t       item,
  output logic                       busy,
  output cprd_pkg::pal_wr_t          pal_wr,
  output cprd_pkg::colour_req_t      creq,
  input  wire cprd_pkg::colour_rsp_t crsp,
  output cprd_pkg::emit_t            em,
  input  wire cprd_pkg::out_status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_UNP, S_PK, S_TAKE, S_CTRL, S_COLOUR, S_EMIT, S_ROWEND, S_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    PH_OFFSET, PH_PREAMBLE, PH_CONTROL, PH_LITERAL, PH_REPEAT, PH_SKIP
  } phase_t;

  localparam logic [11:0] MaxW = 12'(MAX_WIDTH);

  state_t      state;
  phase_t      phase;
  logic [23:0] acc;
  logic [4:0]  held;
  logic [10:0] column;
  logic [10:0] row;
  logic [18:0] rbu;
  logic [18:0] rbl;
  logic [6:0]  run_left;
  logic [7:0]  byte_r;
  logic [15:0] px;
  logic [4:0]  take_left;
  logic        take_ctrl;
  logic [6:0]  nres;
  logic        cstart;

  logic        accept;
  logic [4:0]  bpp;
  logic [10:0] width;
  logic [10:0] rem;
  logic [15:0] wb;
  logic [16:0] wb31;
  logic [18:0] row_bytes;
  logic [23:0] push_val;
  logic [18:0] rbu1;
  logic [18:0] limit;
  logic [6:0]  cnt;
  logic [6:0]  cnt_clip;
  logic [16:0] off16;
  logic        can_out;
  logic [6:0]  lit_left;

  assign busy      = (state != S_IDLE);
  assign accept    = item_valid && !busy;
  assign bpp       = cprd_pkg::depth_bits(cfg.depth_code);
  assign width     = ({1'b0, cfg.image_width} > MaxW) ? MaxW[10:0] : cfg.image_width;
  assign rem       = width - column;
  assign wb        = 16'(width) * 16'(bpp);
  assign wb31      = 17'(wb) + 17'd31;
  assign row_bytes = 19'({wb31[16:5], 2'b00});
  assign push_val  = {byte_r, 16'b0} >> held;
  assign rbu1      = rbu + 19'd1;
  assign limit     = cfg.packed_mode ? rbl : row_bytes;
  assign cnt       = {1'b0, px[5:0]} + 7'd1;
  assign cnt_clip  = ({4'b0, cnt} > rem) ? rem[6:0] : cnt;
  assign off16     = 17'({rbl[7:0], byte_r}) + 17'd2;
  assign can_out   = nres < 7'(cprd_pkg::MAX_RESULTS);
  assign lit_left  = (run_left != 7'd0) ? run_left - 7'd1 : run_left;

  assign pal_wr.we   = accept && item.kind == cprd_pkg::KIND_PALETTE;
  assign pal_wr.slot = item.palette_slot;
  assign pal_wr.word = item.data_word[14:0];

  assign creq.start = cstart;
  assign creq.raw   = px;
  assign creq.is16  = (bpp == 5'd16);

  assign em.push  = (state == S_EMIT) && can_out && status.push_ready;
  assign em.flush = (state == S_FLUSH);
  assign em.x     = column;
  assign em.y     = row;
  assign em.red   = crsp.red;
  assign em.green = crsp.green;
  assign em.blue  = crsp.blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_OFFSET;
      acc      <= '0;
      held     <= '0;
      column   <= '0;
      row      <= '0;
      rbu      <= '0;
      rbl      <= '0;
      run_left <= '0;
      nres     <= '0;
      cstart   <= 1'b0;
    end else begin
      cstart <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept && item.kind != cprd_pkg::KIND_PALETTE) begin
            byte_r <= item.data_word[7:0];
            nres   <= '0;
            if (item.frame_start) begin
              column   <= '0;
              row      <= '0;
              acc      <= '0;
              held     <= '0;
              rbu      <= '0;
              rbl      <= '0;
              run_left <= '0;
              phase    <= (cfg.packed_mode && cfg.preamble_bytes != 3'd0) ?
                          PH_PREAMBLE : PH_OFFSET;
            end
            state <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (bpp == 5'd0 || row >= cfg.image_height) begin
            state <= S_FLUSH;
          end else if (!cfg.packed_mode) begin
            if (width == 11'd0) begin
              state <= S_FLUSH;
            end else if (column < width) begin
              acc   <= acc | push_val;
              held  <= held + 5'd8;
              state <= S_UNP;
            end else begin
              state <= S_ROWEND;
            end
          end else begin
            unique case (phase)
              PH_PREAMBLE: begin
                if (rbu1 >= 19'(cfg.preamble_bytes)) begin
                  rbu   <= '0;
                  phase <= PH_OFFSET;
                end else begin
                  rbu <= rbu1;
                end
                state <= S_FLUSH;
              end
              PH_OFFSET: begin
                if (bpp < 5'd8) begin
                  rbl   <= 19'({{1'b0, byte_r} + 9'd2, 2'b00});
                  phase <= PH_CONTROL;
                end else if (rbu == 19'd0) begin
                  rbl <= 19'(byte_r);
                end else begin
                  rbl   <= {off16, 2'b00};
                  phase <= PH_CONTROL;
                end
                rbu   <= rbu1;
                state <= S_FLUSH;
              end
              PH_SKIP: state <= S_ROWEND;
              default: begin
                acc   <= acc | push_val;
                held  <= held + 5'd8;
                state <= S_PK;
              end
            endcase
          end
        end
        S_UNP: begin
          if (held >= bpp && column < width) begin
            take_left <= bpp;
            take_ctrl <= 1'b0;
            px        <= '0;
            state     <= S_TAKE;
          end else begin
            state <= S_ROWEND;
          end
        end
        S_PK: begin
          unique case (phase)
            PH_CONTROL: begin
              if (column >= width) begin
                phase <= PH_SKIP;
              end else if (held < 5'd8) begin
                state <= S_ROWEND;
              end else begin
                take_left <= 5'd8;
                take_ctrl <= 1'b1;
                px        <= '0;
                state     <= S_TAKE;
              end
            end
            PH_LITERAL, PH_REPEAT: begin
              if (held < bpp) begin
                state <= S_ROWEND;
              end else begin
                take_left <= bpp;
                take_ctrl <= 1'b0;
                px        <= '0;
                state     <= S_TAKE;
              end
            end
            default: begin
              acc   <= '0;
              held  <= '0;
              state <= S_ROWEND;
            end
          endcase
        end
        S_TAKE: begin
          px        <= {px[14:0], acc[23]};
          acc       <= {acc[22:0], 1'b0};
          held      <= held - 5'd1;
          take_left <= take_left - 5'd1;
          if (take_left == 5'd1) begin
            if (take_ctrl) begin
              state <= S_CTRL;
            end else begin
              cstart <= 1'b1;
              state  <= S_COLOUR;
            end
          end
        end
        S_CTRL: begin
          unique case (px[7:6])
            2'd0: phase <= PH_SKIP;
            2'd1: begin
              run_left <= cnt_clip;
              phase    <= PH_LITERAL;
            end
            2'd2: column <= column + 11'(cnt_clip);
            default: begin
              run_left <= cnt_clip;
              phase    <= PH_REPEAT;
            end
          endcase
          state <= S_PK;
        end
        S_COLOUR: begin
          if (crsp.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!can_out || status.push_ready) begin
            column <= column + 11'd1;
            if (can_out) begin
              nres <= nres + 7'd1;
            end
            if (!cfg.packed_mode) begin
              state <= S_UNP;
            end else if (phase == PH_REPEAT) begin
              run_left <= run_left - 7'd1;
              if (run_left == 7'd1) begin
                phase <= PH_CONTROL;
                state <= S_PK;
              end
            end else begin
              run_left <= lit_left;
              if (lit_left == 7'd0) begin
                phase <= PH_CONTROL;
              end
              state <= S_PK;
            end
          end
        end
        S_ROWEND: begin
          if (rbu1 >= limit) begin
            row      <= row + 11'd1;
            column   <= '0;
            acc      <= '0;
            held     <= '0;
            rbu      <= '0;
            run_left <= '0;
            phase    <= PH_OFFSET;
          end else begin
            rbu <= rbu1;
          end
          state <= S_FLUSH;
        end
        S_FLUSH: begin
          if (status.flush_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CPRD_ASSERT_RST(a_push_has_room, em.push |-> status.push_ready, "push without room")
  `CPRD_ASSERT_RST(a_push_in_row, em.push |-> em.x < width, "pixel beyond row width")
  `CPRD_ASSERT_RST(a_colour_waited, crsp.done |-> state == S_COLOUR, "stray colour result")
  `CPRD_ASSERT_CLK(a_reset_idle, rst |=> state == S_IDLE && !em.push, "not idle after reset")

endmodule
`default_nettype wire
